@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    // command codes of an input item
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_START     = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ      = 3'd3,
        CMD_STOP      = 3'd4,
        CMD_REG_WRITE = 3'd5,
        CMD_REG_READ  = 3'd6
    } cmd_t;

    // bus operations that make up a command
    typedef enum logic [3:0] {
        OP_END     = 4'd0,
        OP_START   = 4'd1,
        OP_STOP    = 4'd2,
        OP_WADDR_W = 4'd3,
        OP_WADDR_R = 4'd4,
        OP_WADDR_D = 4'd5,
        OP_WREG    = 4'd6,
        OP_WDATA   = 4'd7,
        OP_RBYTE   = 4'd8,
        OP_RNACK   = 4'd9
    } op_t;

    localparam int unsigned QueueDepth      = 2;
    localparam logic [15:0] HalfBitReset    = 16'd250;
    localparam logic [3:0]  BitsPerByte     = 4'd8;
    localparam logic [3:0]  SlotsPerByte    = 4'd9;
    localparam logic [1:0]  PhasesPerSlot   = 2'd3;

    // input item
    typedef struct packed {
        logic [2:0] command;
        logic [6:0] target_address;
        logic       read_not_write;
        logic [7:0] register_index;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
        logic       refused;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_cmd;
        cmd_t       cmd;
        logic [6:0] addr;
        logic       dir;
        logic [7:0] regidx;
        logic [7:0] data;
        logic       ack;
        logic       sda;
    } cls_item_t;

    // engine state
    typedef struct packed {
        cmd_t        ctrl;
        logic [3:0]  step;
        logic [15:0] phase_cnt;
        logic [1:0]  phase_idx;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic [6:0]  held_addr;
        logic [7:0]  held_reg;
        logic [7:0]  held_data;
        logic        held_dir;
        logic        held_ack;
        logic [1:0]  levels;
        logic        ack_flag;
        logic [7:0]  rx_byte;
    } eng_state_t;

    // operation sequence of each command
    function automatic op_t seq_op(cmd_t cmd, logic [3:0] step);
        op_t op;
        op = OP_END;
        case (cmd)
            CMD_START: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR_D;
                    default: op = OP_END;
                endcase
            end
            CMD_WRITE: begin
                op = (step == 4'd0) ? OP_WDATA : OP_END;
            end
            CMD_READ: begin
                op = (step == 4'd0) ? OP_RBYTE : OP_END;
            end
            CMD_STOP: begin
                op = (step == 4'd0) ? OP_STOP : OP_END;
            end
            CMD_REG_WRITE: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR_W;
                    4'd2:    op = OP_WREG;
                    4'd3:    op = OP_WDATA;
                    4'd4:    op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            CMD_REG_READ: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR_W;
                    4'd2:    op = OP_WREG;
                    4'd3:    op = OP_STOP;
                    4'd4:    op = OP_START;
                    4'd5:    op = OP_WADDR_R;
                    4'd6:    op = OP_RNACK;
                    4'd7:    op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage

@@ rtl/i2cm_front.sv @@
module i2cm_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cm_pkg::in_item_t  s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output i2cm_pkg::cls_item_t push_item
);
    import i2cm_pkg::*;

    // pass the handshake straight to the queue
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // split commands from plain ticks, unused code counts as a tick
    always_comb begin
        push_item.is_cmd = s_data.command inside {[CMD_START:CMD_REG_READ]};
        push_item.cmd    = push_item.is_cmd ? cmd_t'(s_data.command) : CMD_TICK;
        push_item.addr   = s_data.target_address;
        push_item.dir    = s_data.read_not_write;
        push_item.regidx = s_data.register_index;
        push_item.data   = s_data.data_byte;
        push_item.ack    = s_data.send_ack;
        push_item.sda    = s_data.sda_in;
    end

endmodule

@@ rtl/i2cm_queue.sv @@
module i2cm_queue #(
    parameter int unsigned DEPTH = i2cm_pkg::QueueDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cm_pkg::cls_item_t in_item,
    output logic                out_valid,
    input  logic                out_pop,
    output i2cm_pkg::cls_item_t out_item
);
    import i2cm_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    cls_item_t          mem [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               push, pop;

    assign in_ready  = (cnt_reg != CntW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_item  = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/i2cm_back.sv @@
module i2cm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_valid,
    input  i2cm_pkg::cls_item_t q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::out_item_t m_data
);
    import i2cm_pkg::*;

    // idle engine with both lines released
    localparam eng_state_t EngReset = '{ctrl: CMD_TICK, levels: 2'b11, default: '0};

    eng_state_t  st_reg, st_next;
    logic [15:0] half_bit_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg, m_data_next;

    function automatic logic op_is_read(op_t op);
        return (op == OP_RBYTE) || (op == OP_RNACK);
    endfunction

    // line levels for the current op and phase
    function automatic eng_state_t upd_levels(eng_state_t s);
        op_t  op;
        logic scl, sda;
        op = seq_op(s.ctrl, s.step);
        if (op == OP_START) begin
            scl = (s.phase_idx < 2'd2);
            sda = (s.phase_idx == 2'd0);
        end else if (op == OP_STOP) begin
            scl = (s.phase_idx != 2'd0);
            sda = (s.phase_idx == 2'd2);
        end else begin
            scl = (s.phase_idx == 2'd1);
            if (op_is_read(op)) begin
                sda = (s.bit_cnt < BitsPerByte) ? 1'b1 : !((op == OP_RBYTE) && s.held_ack);
            end else begin
                sda = (s.bit_cnt < BitsPerByte) ? s.shift[7] : 1'b1;
            end
        end
        s.levels = {scl, sda};
        return s;
    endfunction

    // set up the next op of the sequence
    function automatic eng_state_t load_op(eng_state_t s);
        op_t        op;
        logic [7:0] a;
        op = seq_op(s.ctrl, s.step);
        a  = {s.held_addr, 1'b0};
        s.phase_idx = '0;
        s.phase_cnt = '0;
        s.bit_cnt   = '0;
        case (op)
            OP_WADDR_W: s.shift = a;
            OP_WADDR_R: s.shift = {s.held_addr, 1'b1};
            OP_WADDR_D: s.shift = {s.held_addr, s.held_dir};
            OP_WREG:    s.shift = s.held_reg;
            OP_WDATA:   s.shift = s.held_data;
            default:    s.shift = '0;
        endcase
        return upd_levels(s);
    endfunction

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one item: start a command or advance the bus by one tick
    always_comb begin
        eng_state_t  nx;
        op_t         op;
        logic        bitop, rd, done, refused, adv;
        logic [15:0] limit, pc;
        logic [1:0]  pi;
        nx      = st_reg;
        done    = 1'b0;
        refused = 1'b0;
        adv     = 1'b0;
        op      = seq_op(st_reg.ctrl, st_reg.step);
        bitop   = (op >= OP_WADDR_W);
        rd      = op_is_read(op);
        limit   = (half_bit_reg == '0) ? 16'd1 : half_bit_reg;
        pc      = st_reg.phase_cnt + 16'd1;
        pi      = st_reg.phase_idx + 2'd1;
        if (q_item.is_cmd && st_reg.ctrl == CMD_TICK) begin
            nx.held_addr = q_item.addr;
            nx.held_dir  = q_item.dir;
            nx.held_reg  = q_item.regidx;
            nx.held_data = q_item.data;
            nx.held_ack  = q_item.ack;
            nx.ctrl      = q_item.cmd;
            nx.step      = '0;
            nx           = load_op(nx);
        end else begin
            refused = q_item.is_cmd;
            if (st_reg.ctrl != CMD_TICK) begin
                if (pc < limit) begin
                    nx.phase_cnt = pc;
                end else begin
                    nx.phase_cnt = '0;
                    // sample at the end of scl high
                    if (bitop && st_reg.phase_idx == 2'd1) begin
                        if (rd) begin
                            if (st_reg.bit_cnt < BitsPerByte) begin
                                nx.shift = {st_reg.shift[6:0], q_item.sda};
                            end
                        end else if (st_reg.bit_cnt == BitsPerByte) begin
                            nx.ack_flag = !q_item.sda;
                        end
                    end
                    if (pi < PhasesPerSlot) begin
                        nx.phase_idx = pi;
                        nx           = upd_levels(nx);
                    end else begin
                        nx.phase_idx = '0;
                        adv          = 1'b1;
                        if (bitop) begin
                            if (!rd && st_reg.bit_cnt < BitsPerByte) begin
                                nx.shift = {nx.shift[6:0], 1'b0};
                            end
                            nx.bit_cnt = st_reg.bit_cnt + 4'd1;
                            if (nx.bit_cnt < SlotsPerByte) begin
                                nx  = upd_levels(nx);
                                adv = 1'b0;
                            end else if (rd) begin
                                nx.rx_byte = nx.shift;
                            end
                        end
                        // move to the next op or finish
                        if (adv) begin
                            nx.step = st_reg.step + 4'd1;
                            if (seq_op(nx.ctrl, nx.step) == OP_END) begin
                                nx.ctrl    = CMD_TICK;
                                nx.step    = '0;
                                nx.bit_cnt = '0;
                                done       = 1'b1;
                            end else begin
                                nx = load_op(nx);
                            end
                        end
                    end
                end
            end
        end
        st_next                 = nx;
        m_data_next.scl_release = nx.levels[1];
        m_data_next.sda_release = nx.levels[0];
        m_data_next.busy_res    = (nx.ctrl != CMD_TICK);
        m_data_next.done_res    = done;
        m_data_next.read_data   = nx.rx_byte;
        m_data_next.ack_seen    = nx.ack_flag;
        m_data_next.refused     = refused;
    end

    // engine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= EngReset;
        end else if (q_pop) begin
            st_reg <= st_next;
        end
    end

    // phase length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_bit_reg <= HalfBitReset;
        end else if (cfg_we) begin
            half_bit_reg <= cfg_wdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ rtl/i2c_master_byte_and_register_engine.sv @@
// Open-drain I2C master driven by a timebase tick stream.
// Input channel s_valid/s_ready/s_data carries one item per tick: a command
// (start+address, write byte, read byte, stop, register write, register read)
// or a plain tick, plus the sampled SDA level. Every accepted item yields
// exactly one result item on m_valid/m_ready/m_data with the SCL/SDA release
// levels, busy, done, last read byte, ack flag and a refused flag for a
// command that came in while busy.
// cfg_we/cfg_wdata set the number of ticks per SCL phase (reset 250, 0 acts as 1).
// Path: an accepted item is written into the front queue, then the engine
// pops it and registers its result in the output register that drives
// m_valid; a stall on m_ready can hold the item in the queue.
// Throughput: one item per cycle while m_ready does not stall the output, set by
// the engine step in the back end which pops one queued item per cycle.
// Reset (aresetn low, synchronous) empties the queue, idles the engine,
// releases both lines and sets the phase length to 250.
// When the receiver holds m_ready low the result stays in the output
// register, the engine stops popping and the 2-entry queue fills; s_ready
// drops once it is full and rises again as soon as results drain.
`include "assert_macros.svh"

module i2c_master_byte_and_register_engine #(
    parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QueueDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    import i2cm_pkg::*;

    logic      push_valid, push_ready;
    cls_item_t push_item;
    logic      q_valid, q_pop;
    cls_item_t q_item;
    logic      res_active;

    // front: accept and classify
    i2cm_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // queue between front and engine
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // back: bus engine and output register
    i2cm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // result belongs to a running or just finished command
    assign res_active = m_data.busy_res || m_data.done_res;

    // a finishing item leaves the engine idle
    `ASSERT_NEVER(a_done_not_busy, aclk, aresetn, m_valid && m_data.done_res && m_data.busy_res)
    // a refused command only happens while a command runs or just finished
    `ASSERT_PROP(a_refused_busy, aclk, aresetn, (m_valid && m_data.refused) |-> res_active)
    // a stalled result holds the engine
    `ASSERT_NEVER(a_stall_no_pop, aclk, aresetn, m_valid && !m_ready && q_pop)

endmodule

@@ tb/tb_i2c_master_byte_and_register_engine.sv @@
module tb_i2c_master_byte_and_register_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // command code outside the defined set, acts as a plain tick
    localparam logic [2:0] CmdSpare = 3'd7;

    // how the slave side drives sda during a command
    localparam int SdaLow    = 0;
    localparam int SdaHigh   = 1;
    localparam int SdaRandom = 2;

    localparam int ResultTail     = 10;
    localparam int MaxPrinted     = 20;
    localparam int NoisePercent   = 5;
    localparam int LongPhaseTicks = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2c_master_byte_and_register_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // bookkeeping
    out_item_t pending_results[$];
    int        items_sent;
    int        results_seen;
    int        errors;
    int        commands_run;
    int        done_count;
    int        refused_count;
    logic      quiet;

    // mirror of the bus engine state
    logic [15:0] bus_half_bit;
    logic [2:0]  bus_cmd;
    logic [3:0]  bus_step;
    logic [15:0] bus_phase_cnt;
    logic [1:0]  bus_phase_idx;
    logic [3:0]  bus_bit_cnt;
    logic [7:0]  bus_shift;
    logic [6:0]  bus_addr;
    logic [7:0]  bus_reg;
    logic [7:0]  bus_data;
    logic        bus_dir;
    logic        bus_ack_choice;
    logic        bus_scl;
    logic        bus_sda;
    logic        bus_ack_flag;
    logic [7:0]  bus_rx;

    function automatic void reset_bus_model();
        bus_half_bit   = HalfBitReset;
        bus_cmd        = CMD_TICK;
        bus_step       = '0;
        bus_phase_cnt  = '0;
        bus_phase_idx  = '0;
        bus_bit_cnt    = '0;
        bus_shift      = '0;
        bus_addr       = '0;
        bus_reg        = '0;
        bus_data       = '0;
        bus_dir        = 1'b0;
        bus_ack_choice = 1'b0;
        bus_scl        = 1'b1;
        bus_sda        = 1'b1;
        bus_ack_flag   = 1'b0;
        bus_rx         = '0;
    endfunction

    // bus operation list of each command
    function automatic op_t seq_op_of(logic [2:0] c, logic [3:0] s);
        op_t ops [0:7];
        int  i;
        for (i = 0; i < 8; i++) ops[i] = OP_END;
        case (c)
            CMD_START: begin
                ops[0] = OP_START;
                ops[1] = OP_WADDR_D;
            end
            CMD_WRITE: ops[0] = OP_WDATA;
            CMD_READ:  ops[0] = OP_RBYTE;
            CMD_STOP:  ops[0] = OP_STOP;
            CMD_REG_WRITE: begin
                ops[0] = OP_START;
                ops[1] = OP_WADDR_W;
                ops[2] = OP_WREG;
                ops[3] = OP_WDATA;
                ops[4] = OP_STOP;
            end
            CMD_REG_READ: begin
                ops[0] = OP_START;
                ops[1] = OP_WADDR_W;
                ops[2] = OP_WREG;
                ops[3] = OP_STOP;
                ops[4] = OP_START;
                ops[5] = OP_WADDR_R;
                ops[6] = OP_RNACK;
                ops[7] = OP_STOP;
            end
            default: ;
        endcase
        return (s < 4'd8) ? ops[s[2:0]] : OP_END;
    endfunction

    function automatic logic is_read_op(op_t op);
        return (op == OP_RBYTE) || (op == OP_RNACK);
    endfunction

    // line levels for the current phase of the current operation
    function automatic void drive_lines();
        op_t op;
        op = seq_op_of(bus_cmd, bus_step);
        if (op == OP_START) begin
            bus_scl = (bus_phase_idx < 2);
            bus_sda = (bus_phase_idx == 0);
        end else if (op == OP_STOP) begin
            bus_scl = (bus_phase_idx > 0);
            bus_sda = (bus_phase_idx == 2);
        end else begin
            bus_scl = (bus_phase_idx == 1);
            if (is_read_op(op)) begin
                bus_sda = (bus_bit_cnt < 8) ? 1'b1 : !(op == OP_RBYTE && bus_ack_choice);
            end else begin
                bus_sda = (bus_bit_cnt < 8) ? bus_shift[7] : 1'b1;
            end
        end
    endfunction

    function automatic void load_bus_op();
        op_t op;
        op = seq_op_of(bus_cmd, bus_step);
        bus_phase_idx = '0;
        bus_phase_cnt = '0;
        bus_bit_cnt   = '0;
        case (op)
            OP_WADDR_W: bus_shift = {bus_addr, 1'b0};
            OP_WADDR_R: bus_shift = {bus_addr, 1'b1};
            OP_WADDR_D: bus_shift = {bus_addr, bus_dir};
            OP_WREG:    bus_shift = bus_reg;
            OP_WDATA:   bus_shift = bus_data;
            default:    bus_shift = '0;
        endcase
        drive_lines();
    endfunction

    // one timebase tick while busy, returns 1 when the command completes
    function automatic logic advance_tick(logic sda);
        op_t         op;
        logic [15:0] lim;
        logic        bit_op;
        lim    = (bus_half_bit == 0) ? 16'd1 : bus_half_bit;
        op     = seq_op_of(bus_cmd, bus_step);
        bit_op = (op >= OP_WADDR_W);
        bus_phase_cnt = bus_phase_cnt + 16'd1;
        if (bus_phase_cnt < lim) return 1'b0;
        bus_phase_cnt = '0;
        // sample sda at the end of the scl high phase
        if (bit_op && bus_phase_idx == 1) begin
            if (is_read_op(op)) begin
                if (bus_bit_cnt < 8) bus_shift = {bus_shift[6:0], sda};
            end else if (bus_bit_cnt == 8) begin
                bus_ack_flag = !sda;
            end
        end
        bus_phase_idx = bus_phase_idx + 2'd1;
        if (bus_phase_idx < 3) begin
            drive_lines();
            return 1'b0;
        end
        bus_phase_idx = '0;
        // end of a bit slot
        if (bit_op) begin
            if (!is_read_op(op) && bus_bit_cnt < 8) bus_shift = bus_shift << 1;
            bus_bit_cnt = bus_bit_cnt + 4'd1;
            if (bus_bit_cnt < 9) begin
                drive_lines();
                return 1'b0;
            end
            if (is_read_op(op)) bus_rx = bus_shift;
        end
        // next operation or back to idle
        bus_step = bus_step + 4'd1;
        if (seq_op_of(bus_cmd, bus_step) == OP_END) begin
            bus_cmd     = CMD_TICK;
            bus_step    = '0;
            bus_bit_cnt = '0;
            return 1'b1;
        end
        load_bus_op();
        return 1'b0;
    endfunction

    function automatic out_item_t predict_bus_lines(in_item_t it);
        out_item_t r;
        logic      is_cmd;
        logic      refused_now;
        logic      done_now;
        is_cmd      = (it.command >= CMD_START) && (it.command <= CMD_REG_READ);
        refused_now = 1'b0;
        done_now    = 1'b0;
        if (is_cmd && bus_cmd == CMD_TICK) begin
            // command taken while idle: latch fields, no time passes
            bus_addr       = it.target_address;
            bus_dir        = it.read_not_write;
            bus_reg        = it.register_index;
            bus_data       = it.data_byte;
            bus_ack_choice = it.send_ack;
            bus_cmd        = it.command;
            bus_step       = '0;
            load_bus_op();
        end else begin
            refused_now = is_cmd;
            if (bus_cmd != CMD_TICK) done_now = advance_tick(it.sda_in);
        end
        r.scl_release = bus_scl;
        r.sda_release = bus_sda;
        r.busy_res    = (bus_cmd != CMD_TICK);
        r.done_res    = done_now;
        r.read_data   = bus_rx;
        r.ack_seen    = bus_ack_flag;
        r.refused     = refused_now;
        return r;
    endfunction

    // bus phases needed to finish each command
    function automatic int cmd_phases(logic [2:0] c);
        case (c)
            CMD_START:     return 30;
            CMD_WRITE:     return 27;
            CMD_READ:      return 27;
            CMD_STOP:      return 3;
            CMD_REG_WRITE: return 87;
            CMD_REG_READ:  return 120;
            default:       return 0;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it = in_item_t'($urandom);
        it.command = CMD_TICK;
        return it;
    endfunction

    function automatic logic pick_sda(int mode);
        if (mode == SdaLow) return 1'b0;
        if (mode == SdaHigh) return 1'b1;
        return 1'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < MaxPrinted) $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s got %0h expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("scl_release", 8'(m_data.scl_release), 8'(want.scl_release));
                check_field("sda_release", 8'(m_data.sda_release), 8'(want.sda_release));
                check_field("busy_res", 8'(m_data.busy_res), 8'(want.busy_res));
                check_field("done_res", 8'(m_data.done_res), 8'(want.done_res));
                check_field("read_data", m_data.read_data, want.read_data);
                check_field("ack_seen", 8'(m_data.ack_seen), 8'(want.ack_seen));
                check_field("refused", 8'(m_data.refused), 8'(want.refused));
                if (want.done_res) done_count++;
                if (want.refused) refused_count++;
            end
        end
    end

    // result side stalls
    initial begin : result_stall
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // one item through the handshake, prediction taken on acceptance
    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_bus_lines(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
    endtask

    task automatic set_half_bit(input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        bus_half_bit = value;
    endtask

    // ticks while idle: plain ticks and the spare code
    task automatic idle_noise(input int count);
        in_item_t it;
        repeat (count) begin
            it = random_item();
            if ($urandom_range(0, 1)) it.command = CmdSpare;
            send_item(it);
        end
    endtask

    // one command and exactly the ticks that take it to completion
    task automatic run_cmd(input logic [2:0] c, input logic [6:0] a, input logic rw,
                           input logic [7:0] ri, input logic [7:0] d, input logic ack,
                           input int sda_mode, input int noise_pct);
        in_item_t it;
        int       ticks;
        it = random_item();
        it.command        = c;
        it.target_address = a;
        it.read_not_write = rw;
        it.register_index = ri;
        it.data_byte      = d;
        it.send_ack       = ack;
        send_item(it);
        ticks = cmd_phases(c) * ((bus_half_bit == 0) ? 1 : int'(bus_half_bit));
        repeat (ticks) begin
            it = random_item();
            // commands while busy are refused but still count as ticks
            if ($urandom_range(0, 99) < noise_pct) begin
                it.command = 3'($urandom_range(int'(CMD_START), int'(CmdSpare)));
            end
            it.sda_in = pick_sda(sda_mode);
            send_item(it);
        end
        commands_run++;
    endtask

    task automatic run_random_cmd(input logic [2:0] c);
        run_cmd(c, 7'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), SdaRandom, NoisePercent);
    endtask

    // reset phase length of 250: a stop past its first phase, then finished fast
    task automatic test_default_phase();
        in_item_t it;
        idle_noise(3);
        it = random_item();
        it.command = CMD_STOP;
        send_item(it);
        repeat (int'(HalfBitReset) + 5) begin
            it = random_item();
            send_item(it);
        end
        commands_run++;
        // a short phase lets the stop run out
        set_half_bit(16'd1);
        while (bus_cmd != CMD_TICK) begin
            it = random_item();
            send_item(it);
        end
        idle_noise(2);
    endtask

    // byte level commands at field extremes
    task automatic test_byte_commands();
        in_item_t it;
        set_half_bit(16'd1);
        it = '1;
        it.command = CmdSpare;
        send_item(it);
        it = '0;
        send_item(it);
        run_cmd(CMD_START, 7'h00, 1'b0, 8'h00, 8'h00, 1'b0, SdaLow, 0);
        run_cmd(CMD_WRITE, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b1, SdaHigh, 0);
        run_cmd(CMD_WRITE, 7'h00, 1'b0, 8'h00, 8'h00, 1'b0, SdaLow, 0);
        run_cmd(CMD_READ, 7'h00, 1'b0, 8'h00, 8'h00, 1'b1, SdaHigh, 0);
        run_cmd(CMD_READ, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b0, SdaLow, 0);
        run_cmd(CMD_STOP, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b1, SdaRandom, 0);
        run_cmd(CMD_START, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b1, SdaHigh, 0);
        run_random_cmd(CMD_READ);
        run_random_cmd(CMD_STOP);
        // lines stay where the last command left them
        idle_noise(2);
    endtask

    task automatic test_register_commands();
        run_cmd(CMD_REG_WRITE, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b1, SdaLow, 0);
        run_cmd(CMD_REG_READ, 7'h00, 1'b0, 8'h00, 8'h00, 1'b1, SdaHigh, 0);
    endtask

    // every command code while busy is refused
    task automatic test_busy_commands();
        run_cmd(CMD_REG_READ, 7'($urandom), 1'b0, 8'($urandom), 8'($urandom),
                1'b1, SdaRandom, 50);
        run_cmd(CMD_WRITE, 7'($urandom), 1'b1, 8'($urandom), 8'($urandom),
                1'b0, SdaRandom, 100);
        idle_noise(2);
    endtask

    // a phase length of zero behaves as one
    task automatic test_zero_phase();
        set_half_bit(16'd0);
        run_cmd(CMD_START, 7'h3C, 1'b0, 8'h00, 8'h00, 1'b0, SdaLow, 0);
        run_cmd(CMD_WRITE, 7'h00, 1'b0, 8'h00, 8'hA5, 1'b0, SdaRandom, 0);
        run_random_cmd(CMD_STOP);
    endtask

    // well-formed transfers with random content plus some noise
    task automatic test_random_traffic(input logic [15:0] half_bit, input int budget);
        int   first;
        int   r;
        int   nbytes;
        int   i;
        logic rw;
        set_half_bit(half_bit);
        first = items_sent;
        while (items_sent - first < budget) begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 40) begin
                rw = 1'($urandom);
                run_cmd(CMD_START, 7'($urandom), rw, 8'($urandom), 8'($urandom),
                        1'($urandom), SdaRandom, NoisePercent);
                nbytes = $urandom_range(1, 3);
                for (i = 0; i < nbytes; i++) begin
                    // occasionally the wrong direction for the address sent
                    if (rw ^ ($urandom_range(0, 9) == 0)) begin
                        run_cmd(CMD_READ, 7'($urandom), 1'($urandom), 8'($urandom),
                                8'($urandom), (i < nbytes - 1), SdaRandom, NoisePercent);
                    end else begin
                        run_random_cmd(CMD_WRITE);
                    end
                end
                run_random_cmd(CMD_STOP);
            end else if (r < 70) begin
                run_random_cmd($urandom_range(0, 1) ? CMD_REG_WRITE : CMD_REG_READ);
            end else if (r < 85) begin
                run_random_cmd(3'($urandom_range(int'(CMD_START), int'(CMD_REG_READ))));
            end else begin
                idle_noise($urandom_range(1, 5));
            end
            if ($urandom_range(0, 19) == 0) wait_idle();
        end
        quiet = 1'b0;
    endtask

    // longest phase: the lines hold through the start of a stop, left running
    task automatic test_longest_phase();
        in_item_t it;
        set_half_bit(16'hFFFF);
        quiet = 1'b1;
        it = random_item();
        it.command = CMD_STOP;
        send_item(it);
        repeat (LongPhaseTicks) begin
            it = random_item();
            if ($urandom_range(0, 9) == 0) begin
                it.command = 3'($urandom_range(int'(CMD_START), int'(CmdSpare)));
            end
            send_item(it);
        end
        quiet = 1'b0;
    endtask

    initial begin
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        quiet = 1'b0;
        items_sent = 0;
        results_seen = 0;
        errors = 0;
        commands_run = 0;
        done_count = 0;
        refused_count = 0;
        reset_bus_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_phase();
        test_byte_commands();
        test_register_commands();
        test_busy_commands();
        test_zero_phase();
        test_random_traffic(16'd1, 120);
        test_random_traffic(16'd2, 60);
        test_longest_phase();

        // drain and let the pipeline settle
        wait_idle();
        repeat (ResultTail) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        $display("run covered %0d items and %0d results, phase lengths 250, 1, 0, 2, 65535",
                 items_sent, results_seen);
        $display("%0d commands issued, %0d completions and %0d refused commands checked",
                 commands_run, done_count, refused_count);
        if (errors == 0) begin
            $display("tb_i2c_master_byte_and_register_engine: PASS");
        end else begin
            $display("tb_i2c_master_byte_and_register_engine: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d results still expected", items_sent - results_seen);
        $display("tb_i2c_master_byte_and_register_engine: FAIL");
        $finish;
    end

endmodule
